/* rtl/pps_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_pkg - shared types and constants of the pure pursuit controller
// Command and status structs, configuration layout, CORDIC constants.
// ---------------------------------------------------------------------------
package pps_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_USE_FIXED   = 3'd0;
  localparam logic [2:0] REG_FIXED_SPEED = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN  = 3'd2;
  localparam logic [2:0] REG_LA_GAIN     = 3'd3;
  localparam logic [2:0] REG_LA_MIN      = 3'd4;
  localparam logic [2:0] REG_WHEEL_BASE  = 3'd5;
  localparam logic [2:0] REG_BRAKE       = 3'd6;

  // outcome codes
  localparam logic [1:0] OUT_TRACK  = 2'd0;
  localparam logic [1:0] OUT_NOPATH = 2'd1;
  localparam logic [1:0] OUT_STOP   = 2'd2;

  // datapath operations
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_START    = 5'd2;
  localparam logic [4:0] OP_DIF1     = 5'd3;
  localparam logic [4:0] OP_DIF2     = 5'd4;
  localparam logic [4:0] OP_M0       = 5'd5;
  localparam logic [4:0] OP_M1       = 5'd6;
  localparam logic [4:0] OP_M2       = 5'd7;
  localparam logic [4:0] OP_BEST     = 5'd8;
  localparam logic [4:0] OP_NEAR     = 5'd9;
  localparam logic [4:0] OP_ACCEL    = 5'd10;
  localparam logic [4:0] OP_LA2      = 5'd11;
  localparam logic [4:0] OP_SC_HEAD  = 5'd12;
  localparam logic [4:0] OP_SC_ALPHA = 5'd13;
  localparam logic [4:0] OP_WRAP     = 5'd14;
  localparam logic [4:0] OP_FOLD     = 5'd15;
  localparam logic [4:0] OP_ROT      = 5'd16;
  localparam logic [4:0] OP_SAVE_H   = 5'd17;
  localparam logic [4:0] OP_SAVE_A   = 5'd18;
  localparam logic [4:0] OP_RXMUL    = 5'd19;
  localparam logic [4:0] OP_RX       = 5'd20;
  localparam logic [4:0] OP_HIT      = 5'd21;
  localparam logic [4:0] OP_AT_PT    = 5'd22;
  localparam logic [4:0] OP_AT_ST    = 5'd23;
  localparam logic [4:0] OP_AT_NEG   = 5'd24;
  localparam logic [4:0] OP_NORM     = 5'd25;
  localparam logic [4:0] OP_VEC      = 5'd26;
  localparam logic [4:0] OP_STEER    = 5'd27;
  localparam logic [4:0] OP_EMIT     = 5'd28;

  // angle constants, signed Q30 radians; CORDIC gain in Q30, STEER_LIMIT in Q12 radians
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [59:0] CORDIC_K    = 60'sd652032875;
  localparam logic signed [35:0] STEER_LIMIT = 36'sd12868;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic no_path;
    logic goal;
    logic wrap_ok;
    logic iter_last;
    logic at_zero;
    logic norm_ok;
    logic hit;
  } status_t;

  typedef struct packed {
    logic               use_fixed;
    logic signed [15:0] fixed_speed;
    logic [15:0]        speed_gain;
    logic [15:0]        la_gain;
    logic [15:0]        la_min;
    logic [13:0]        wheel_base;
    logic signed [15:0] brake;
  } cfg_t;

  // arctangent of 2^-i, Q30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837830;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/pps_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_in_if - input channel
// Path point or odometry beat with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pps_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] speed;
  logic signed [14:0] heading;
  logic               last_point;
  logic [63:0]        stamp;

  modport source (output valid, mode, pos_x, pos_y, speed, heading, last_point, stamp,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, speed, heading, last_point, stamp,
                output ready);
endinterface

/* rtl/pps_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_out_if - command channel
// One steering/speed command beat per odometry query.
// ---------------------------------------------------------------------------
interface pps_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic signed [15:0] cmd_speed;
  logic signed [15:0] cmd_accel;
  logic               accel_defined;
  logic signed [14:0] steer_angle;
  logic [63:0]        cmd_stamp;

  modport source (output valid, outcome, cmd_speed, cmd_accel, accel_defined, steer_angle,
                  cmd_stamp, input ready);
  modport sink (input valid, outcome, cmd_speed, cmd_accel, accel_defined, steer_angle,
                cmd_stamp, output ready);
endinterface

/* rtl/pps_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_dp - pure pursuit datapath
// Point store, distance squarer, shared CORDIC unit and result registers.
// ---------------------------------------------------------------------------
module pps_dp #(
  parameter int MAX_POINTS       = 256,
  parameter int CORDIC_STEPS     = 16,
  parameter int SHORT_PATH_LIMIT = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pps_pkg::cmd_t      cmd,
  output pps_pkg::status_t   sts,
  input  pps_pkg::cfg_t      cfg,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [15:0] in_speed,
  input  logic signed [14:0] in_heading,
  input  logic               in_last_point,
  input  logic [63:0]        in_stamp,
  output logic [1:0]         out_outcome,
  output logic signed [15:0] out_cmd_speed,
  output logic signed [15:0] out_cmd_accel,
  output logic               out_accel_defined,
  output logic signed [14:0] out_steer_angle,
  output logic [63:0]        out_cmd_stamp
);
  import pps_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // point store
  logic [79:0] mem [MAX_POINTS];
  logic [79:0] rd_q;
  logic [IW-1:0] idx_r, idx_nxt, near_r;

  logic [CW-1:0] cnt_load_r, cnt_path_r;
  logic          complete_r;

  logic signed [31:0] px_r, py_r;
  logic signed [15:0] spd_r;
  logic signed [35:0] h30_r;
  logic [63:0]        stamp_r;

  logic [33:0] ax_r, ay_r;
  logic [50:0] p1_r, p2_r;
  logic [69:0] acc_r, best_r;

  logic signed [15:0] cv_r, ca_r;
  logic signed [27:0] la_r;
  logic [55:0]        la2_r;

  logic signed [59:0] cx_r, cy_r;
  logic signed [35:0] cz_r, base_r;
  logic [4:0]         it_r;
  logic               neg_r;
  logic signed [33:0] sin_r, cos_r, sa_r;
  logic signed [48:0] mc_r, ms_r;
  logic signed [33:0] rx_r, ry_r;
  logic signed [14:0] steer_r;

  logic signed [31:0] rd_x, rd_y;
  logic signed [15:0] rd_s;
  assign rd_x = rd_q[79:48];
  assign rd_y = rd_q[47:16];
  assign rd_s = rd_q[15:0];

  // combinational helpers
  logic signed [33:0] dx, dy, ref_x, ref_y;
  logic signed [15:0] tgt_v;
  logic signed [33:0] acc_p, acc_t, la_p, la_t;
  logic signed [59:0] abs_x, abs_y, mag;
  logic signed [59:0] sx, sy;
  logic signed [35:0] atan_v, steer_t, ang;
  logic               la_le0, last_idx;

  always_comb begin
    ref_x = (cmd.op == OP_DIF2) ? rx_r : 34'(px_r);
    ref_y = (cmd.op == OP_DIF2) ? ry_r : 34'(py_r);
    dx = 34'(rd_x) - ref_x;
    dy = 34'(rd_y) - ref_y;
    tgt_v = cfg.use_fixed ? cfg.fixed_speed : rd_s;
    acc_p = (34'(tgt_v) - 34'(spd_r)) * 34'($signed({1'b0, cfg.speed_gain}));
    acc_t = (acc_p + 34'sd128) >>> 8;
    la_p = 34'(tgt_v) * 34'($signed({1'b0, cfg.la_gain}));
    la_t = (la_p + 34'sd32) >>> 6;
    abs_x = cx_r[59] ? -cx_r : cx_r;
    abs_y = cy_r[59] ? -cy_r : cy_r;
    mag = ($unsigned(abs_x) > $unsigned(abs_y)) ? abs_x : abs_y;
    sx = cx_r >>> it_r;
    sy = cy_r >>> it_r;
    atan_v = $signed(36'(atan_q30(it_r)));
    ang = base_r + cz_r;
    steer_t = (ang + 36'sd131072) >>> 18;
    la_le0 = la_r[27] || (la_r == '0);
    last_idx = (CW'(idx_r) + CW'(1)) == cnt_path_r;
  end

  // status to the controller
  always_comb begin
    sts.last_idx  = last_idx;
    sts.no_path   = !complete_r || (cnt_path_r == '0);
    sts.goal      = ((CW'(near_r) + CW'(1)) == cnt_path_r) ||
                    (32'(cnt_path_r) <= 32'(SHORT_PATH_LIMIT));
    sts.wrap_ok   = (cz_r <= Q30_PI) && (cz_r >= -Q30_PI);
    sts.iter_last = it_r == 5'(CORDIC_STEPS - 1);
    sts.at_zero   = (cx_r == '0) && (cy_r == '0);
    sts.norm_ok   = ($unsigned(mag) < (60'd1 << 41)) && ($unsigned(mag) >= (60'd1 << 40));
    sts.hit       = la_le0 || (acc_r >= 70'(la2_r));
  end

  // store index: advanced by the distance passes
  always_comb begin
    idx_nxt = idx_r;
    unique case (cmd.op)
      OP_START: idx_nxt = '0;
      OP_BEST:  if (!last_idx) idx_nxt = idx_r + IW'(1);
      OP_HIT:   if (!last_idx && !sts.hit) idx_nxt = idx_r + IW'(1);
      OP_NEAR:  idx_nxt = near_r;
      default:  idx_nxt = idx_r;
    endcase
  end

  // memory write on load, registered read at the next index
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && cnt_load_r < CW'(MAX_POINTS)) begin
      mem[cnt_load_r[IW-1:0]] <= {in_pos_x, in_pos_y, in_speed};
    end
    rd_q <= mem[idx_nxt];
  end

  // path bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_load_r <= '0;
      cnt_path_r <= '0;
      complete_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      if (in_last_point) begin
        cnt_path_r <= (cnt_load_r < CW'(MAX_POINTS)) ? cnt_load_r + CW'(1) : cnt_load_r;
        complete_r <= 1'b1;
        cnt_load_r <= '0;
      end else begin
        if (cnt_load_r == '0) begin
          complete_r <= 1'b0;
          cnt_path_r <= '0;
        end
        if (cnt_load_r < CW'(MAX_POINTS)) cnt_load_r <= cnt_load_r + CW'(1);
      end
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    unique case (cmd.op)
      OP_START: begin
        px_r    <= in_pos_x;
        py_r    <= in_pos_y;
        spd_r   <= in_speed;
        h30_r   <= {{3{in_heading[14]}}, in_heading, 18'd0};
        stamp_r <= in_stamp;
      end
      OP_DIF1, OP_DIF2: begin
        ax_r <= dx[33] ? $unsigned(-dx) : $unsigned(dx);
        ay_r <= dy[33] ? $unsigned(-dy) : $unsigned(dy);
      end
      OP_M0: begin
        p1_r <= 51'(ax_r) * 51'(ax_r[16:0]);
        p2_r <= 51'(ay_r) * 51'(ay_r[16:0]);
      end
      OP_M1: begin
        acc_r <= 70'(p1_r) + 70'(p2_r);
        p1_r  <= 51'(ax_r) * 51'(ax_r[33:17]);
        p2_r  <= 51'(ay_r) * 51'(ay_r[33:17]);
      end
      OP_M2: acc_r <= acc_r + ((70'(p1_r) + 70'(p2_r)) << 17);
      OP_BEST: begin
        if (idx_r == '0 || acc_r < best_r) begin
          best_r <= acc_r;
          near_r <= idx_r;
        end
      end
      OP_ACCEL: begin
        cv_r <= tgt_v;
        if (acc_t > 34'sd32767) ca_r <= 16'sd32767;
        else if (acc_t < -34'sd32768) ca_r <= -16'sd32768;
        else ca_r <= 16'(acc_t);
        la_r <= 28'(la_t) + 28'($signed({1'b0, cfg.la_min}));
      end
      OP_LA2: la2_r <= $unsigned(56'(la_r) * 56'(la_r));
      OP_SC_HEAD, OP_SC_ALPHA: begin
        cz_r  <= (cmd.op == OP_SC_HEAD) ? h30_r : ang - h30_r;
        cx_r  <= CORDIC_K;
        cy_r  <= '0;
        it_r  <= '0;
        neg_r <= 1'b0;
      end
      OP_WRAP: begin
        if (cz_r > Q30_PI) cz_r <= cz_r - Q30_TWO_PI;
        else if (cz_r < -Q30_PI) cz_r <= cz_r + Q30_TWO_PI;
      end
      OP_FOLD: begin
        if (cz_r > Q30_HALF_PI) begin
          cz_r  <= cz_r - Q30_PI;
          neg_r <= 1'b1;
        end else if (cz_r < -Q30_HALF_PI) begin
          cz_r  <= cz_r + Q30_PI;
          neg_r <= 1'b1;
        end
      end
      // rotation step
      OP_ROT: begin
        if (!cz_r[35]) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          cz_r <= cz_r + atan_v;
        end
        it_r <= it_r + 5'd1;
      end
      OP_SAVE_H: begin
        sin_r <= neg_r ? 34'(-cy_r) : 34'(cy_r);
        cos_r <= neg_r ? 34'(-cx_r) : 34'(cx_r);
      end
      OP_SAVE_A: sa_r <= neg_r ? 34'(-cy_r) : 34'(cy_r);
      // rear axle offset
      OP_RXMUL: begin
        mc_r <= 49'($signed({1'b0, cfg.wheel_base})) * 49'(cos_r) + (49'sd1 <<< 30);
        ms_r <= 49'($signed({1'b0, cfg.wheel_base})) * 49'(sin_r) + (49'sd1 <<< 30);
      end
      OP_RX: begin
        rx_r <= 34'(px_r) - 34'(mc_r >>> 31);
        ry_r <= 34'(py_r) - 34'(ms_r >>> 31);
      end
      OP_AT_PT, OP_AT_ST: begin
        if (cmd.op == OP_AT_PT) begin
          cx_r <= 60'(34'(rd_x) - rx_r) ;
          cy_r <= 60'(34'(rd_y) - ry_r);
        end else begin
          cx_r <= 60'(la_r) <<< 30;
          cy_r <= 60'($signed({1'b0, cfg.wheel_base, 1'b0})) * 60'(sa_r);
        end
        cz_r   <= '0;
        base_r <= '0;
        it_r   <= '0;
      end
      OP_AT_NEG: begin
        if (cx_r[59]) begin
          base_r <= cy_r[59] ? -Q30_PI : Q30_PI;
          cx_r   <= -cx_r;
          cy_r   <= -cy_r;
        end
      end
      OP_NORM: begin
        if ($unsigned(mag) >= (60'd1 << 41)) begin
          cx_r <= cx_r >>> 1;
          cy_r <= cy_r >>> 1;
        end else begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      // vectoring step
      OP_VEC: begin
        if (!cy_r[59] && cy_r != '0) begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          cz_r <= cz_r + atan_v;
        end else begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          cz_r <= cz_r - atan_v;
        end
        it_r <= it_r + 5'd1;
      end
      OP_STEER: begin
        if (steer_t > STEER_LIMIT) steer_r <= 15'(STEER_LIMIT);
        else if (steer_t < -STEER_LIMIT) steer_r <= 15'(-STEER_LIMIT);
        else steer_r <= 15'(steer_t);
      end
      // result register
      OP_EMIT: begin
        out_outcome       <= cmd.kind;
        out_cmd_speed     <= (cmd.kind == OUT_TRACK) ? cv_r : 16'sd0;
        out_cmd_accel     <= (cmd.kind == OUT_TRACK) ? ca_r :
                             (cmd.kind == OUT_STOP) ? cfg.brake : 16'sd0;
        out_accel_defined <= cmd.kind == OUT_STOP;
        out_steer_angle   <= (cmd.kind == OUT_TRACK) ? steer_r : 15'sd0;
        out_cmd_stamp     <= stamp_r;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pps_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_ctrl - pure pursuit sequencer
// Walks the datapath through the distance passes, CORDIC runs and output.
// ---------------------------------------------------------------------------
module pps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  pps_pkg::status_t sts,
  output pps_pkg::cmd_t    cmd
);
  import pps_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_DIF  = 5'd2;
  localparam logic [4:0] S_M0   = 5'd3;
  localparam logic [4:0] S_M1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_BEST = 5'd6;
  localparam logic [4:0] S_DEC  = 5'd7;
  localparam logic [4:0] S_NEAR = 5'd8;
  localparam logic [4:0] S_ACC  = 5'd9;
  localparam logic [4:0] S_LA2  = 5'd10;
  localparam logic [4:0] S_HLD  = 5'd11;
  localparam logic [4:0] S_WRAP = 5'd12;
  localparam logic [4:0] S_FOLD = 5'd13;
  localparam logic [4:0] S_ROT  = 5'd14;
  localparam logic [4:0] S_HSV  = 5'd15;
  localparam logic [4:0] S_RXM  = 5'd16;
  localparam logic [4:0] S_RX   = 5'd17;
  localparam logic [4:0] S_HIT  = 5'd18;
  localparam logic [4:0] S_ATP  = 5'd19;
  localparam logic [4:0] S_ANEG = 5'd20;
  localparam logic [4:0] S_NORM = 5'd21;
  localparam logic [4:0] S_VEC  = 5'd22;
  localparam logic [4:0] S_ALD  = 5'd23;
  localparam logic [4:0] S_ASV  = 5'd24;
  localparam logic [4:0] S_ATS  = 5'd25;
  localparam logic [4:0] S_STR  = 5'd26;
  localparam logic [4:0] S_DONE = 5'd27;

  logic [4:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       p2_r, p2_nxt;     // second distance pass
  logic       sc2_r, sc2_nxt;   // sin/cos of alpha
  logic       at2_r, at2_nxt;   // steering atan2
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    p2_nxt        = p2_r;
    sc2_nxt       = sc2_r;
    at2_nxt       = at2_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.kind      = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op    = OP_START;
            p2_nxt    = 1'b0;
            sc2_nxt   = 1'b0;
            at2_nxt   = 1'b0;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts.no_path) begin
          kind_nxt  = OUT_NOPATH;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIF;
        end
      end
      S_DIF: begin
        cmd.op    = p2_r ? OP_DIF2 : OP_DIF1;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.op    = OP_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = p2_r ? S_HIT : S_BEST;
      end
      S_BEST: begin
        cmd.op    = OP_BEST;
        state_nxt = sts.last_idx ? S_DEC : S_DIF;
      end
      S_DEC: begin
        if (sts.goal) begin
          kind_nxt  = OUT_STOP;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NEAR;
        end
      end
      S_NEAR: begin
        cmd.op    = OP_NEAR;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACCEL;
        state_nxt = S_LA2;
      end
      S_LA2: begin
        cmd.op    = OP_LA2;
        state_nxt = S_HLD;
      end
      S_HLD: begin
        cmd.op    = OP_SC_HEAD;
        state_nxt = S_WRAP;
      end
      // angle reduction, one 2*pi step a cycle
      S_WRAP: begin
        if (sts.wrap_ok) state_nxt = S_FOLD;
        else cmd.op = OP_WRAP;
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT;
        if (sts.iter_last) state_nxt = sc2_r ? S_ASV : S_HSV;
      end
      S_HSV: begin
        cmd.op    = OP_SAVE_H;
        state_nxt = S_RXM;
      end
      S_RXM: begin
        cmd.op    = OP_RXMUL;
        state_nxt = S_RX;
      end
      S_RX: begin
        cmd.op    = OP_RX;
        p2_nxt    = 1'b1;
        state_nxt = S_DIF;
      end
      S_HIT: begin
        cmd.op    = OP_HIT;
        state_nxt = (sts.hit || sts.last_idx) ? S_ATP : S_DIF;
      end
      S_ATP: begin
        cmd.op    = OP_AT_PT;
        state_nxt = S_ANEG;
      end
      S_ANEG: begin
        if (sts.at_zero) begin
          state_nxt = at2_r ? S_STR : S_ALD;
        end else begin
          cmd.op    = OP_AT_NEG;
          state_nxt = S_NORM;
        end
      end
      // normalise one bit a cycle
      S_NORM: begin
        if (sts.norm_ok) state_nxt = S_VEC;
        else cmd.op = OP_NORM;
      end
      S_VEC: begin
        cmd.op = OP_VEC;
        if (sts.iter_last) state_nxt = at2_r ? S_STR : S_ALD;
      end
      S_ALD: begin
        cmd.op    = OP_SC_ALPHA;
        sc2_nxt   = 1'b1;
        state_nxt = S_WRAP;
      end
      S_ASV: begin
        cmd.op    = OP_SAVE_A;
        state_nxt = S_ATS;
      end
      S_ATS: begin
        cmd.op    = OP_AT_ST;
        at2_nxt   = 1'b1;
        state_nxt = S_ANEG;
      end
      S_STR: begin
        cmd.op    = OP_STEER;
        kind_nxt  = OUT_TRACK;
        state_nxt = S_DONE;
      end
      // wait for the output register to free up
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= OUT_NOPATH;
      p2_r        <= 1'b0;
      sc2_r       <= 1'b0;
      at2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      p2_r        <= p2_nxt;
      sc2_r       <= sc2_nxt;
      at2_r       <= at2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/pure_pursuit_steering_controller.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pure_pursuit_steering_controller - pure pursuit path tracking block
// Stores a path, answers each odometry beat with one speed/steer command.
// ---------------------------------------------------------------------------
// channel  direction  beat
// in_ch    sink       path point (mode 0) or odometry query (mode 1)
// out_ch   source     command, one per query
// cfg_*    write      register index and data, no handshake
//
// Path points are stored without leaving idle. A query with no path goes
// straight to the output; one that ends in a stop, after a first walk over
// the N stored points. Otherwise it walks on from the nearest point to the
// lookahead point (one memory read port, sequential squarer) and makes two
// CORDIC rotation and up to two normalised vectoring runs, CORDIC_STEPS each.
// Reset is synchronous, active low; no clearing pass. A finished command
// waits in the output register while the next beat is accepted.
// ---------------------------------------------------------------------------
module pure_pursuit_steering_controller #(
  parameter int MAX_POINTS       = 256,
  parameter int CORDIC_STEPS     = 16,
  parameter int SHORT_PATH_LIMIT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  pps_in_if.sink      in_ch,
  pps_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);
  import pps_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_fixed   <= 1'b0;
      cfg_r.fixed_speed <= 16'sd0;
      cfg_r.speed_gain  <= 16'd256;
      cfg_r.la_gain     <= 16'd256;
      cfg_r.la_min      <= 16'd4096;
      cfg_r.wheel_base  <= 14'd2867;
      cfg_r.brake       <= -16'sd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_USE_FIXED:   cfg_r.use_fixed   <= cfg_data[0];
        REG_FIXED_SPEED: cfg_r.fixed_speed <= $signed(cfg_data);
        REG_SPEED_GAIN:  cfg_r.speed_gain  <= cfg_data;
        REG_LA_GAIN:     cfg_r.la_gain     <= cfg_data;
        REG_LA_MIN:      cfg_r.la_min      <= cfg_data;
        REG_WHEEL_BASE:  cfg_r.wheel_base  <= cfg_data[13:0];
        REG_BRAKE:       cfg_r.brake       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pps_dp #(
    .MAX_POINTS       (MAX_POINTS),
    .CORDIC_STEPS     (CORDIC_STEPS),
    .SHORT_PATH_LIMIT (SHORT_PATH_LIMIT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg_r),
    .in_pos_x          (in_ch.pos_x),
    .in_pos_y          (in_ch.pos_y),
    .in_speed          (in_ch.speed),
    .in_heading        (in_ch.heading),
    .in_last_point     (in_ch.last_point),
    .in_stamp          (in_ch.stamp),
    .out_outcome       (out_ch.outcome),
    .out_cmd_speed     (out_ch.cmd_speed),
    .out_cmd_accel     (out_ch.cmd_accel),
    .out_accel_defined (out_ch.accel_defined),
    .out_steer_angle   (out_ch.steer_angle),
    .out_cmd_stamp     (out_ch.cmd_stamp)
  );

endmodule

/* tb/pps_cmd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_cmd_checker - command predictor and scoreboard
// Watches the path/odometry channel, the command channel and the register
// port. Keeps its own copy of the path store and registers, works out the
// command for every accepted query and compares each command beat in order.
// ---------------------------------------------------------------------------
module pps_cmd_checker (
  input  logic        clk,
  input  logic        rst_n,
  pps_in_if           in_mon,
  pps_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  output int          fail_cnt,
  output int          pending,
  output int          n_track,
  output int          n_nopath,
  output int          n_stop
);
  import pps_pkg::*;

  localparam longint PI30     = Q30_PI;
  localparam longint HALF_PI  = Q30_HALF_PI;
  localparam longint TWO_PI   = Q30_TWO_PI;
  localparam longint K_GAIN   = CORDIC_K;
  localparam longint MAG_HI   = 64'sh200_0000_0000;
  localparam longint MAG_LO   = 64'sh100_0000_0000;
  localparam longint STEER_MAX = 12868;
  localparam int     STORE_DEPTH = 256;
  localparam int     SHORT_LIMIT = 5;
  localparam int     ROT_STEPS   = 16;

  localparam longint ATAN_LUT [16] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  typedef struct packed {
    logic [1:0]         outcome;
    logic signed [15:0] speed;
    logic signed [15:0] accel;
    logic               accel_def;
    logic signed [14:0] steer;
    logic [63:0]        stamp;
  } command_t;

  // predictor state
  int          pt_x [STORE_DEPTH];
  int          pt_y [STORE_DEPTH];
  shortint     pt_spd [STORE_DEPTH];
  int          path_len;
  int          fill_idx;
  bit          path_ready;
  cfg_t        regs;
  command_t    cmd_q [$];

  function automatic longint mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [127:0] sq_dist(input longint dx, input longint dy);
    logic [127:0] ax, ay;
    ax = 128'(mag_of(dx));
    ay = 128'(mag_of(dy));
    return ax * ax + ay * ay;
  endfunction

  // rotation mode CORDIC, Q30 angle in, Q30 sine and cosine out
  function automatic void rot_sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, xs, ys;
    bit flip;
    x = K_GAIN;
    y = 0;
    z = ang;
    flip = 0;
    while (z > PI30) z -= TWO_PI;
    while (z < -PI30) z += TWO_PI;
    if (z > HALF_PI) begin
      z -= PI30;
      flip = 1;
    end else if (z < -HALF_PI) begin
      z += PI30;
      flip = 1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_LUT[i];
      end else begin
        x += ys; y -= xs; z += ATAN_LUT[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // vectoring mode CORDIC, angle of (x, y) in Q30
  function automatic longint vec_angle(input longint y_in, input longint x_in);
    longint x, y, z, base, xs, ys, mag;
    x = x_in;
    y = y_in;
    z = 0;
    base = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    mag = (mag_of(x) > mag_of(y)) ? mag_of(x) : mag_of(y);
    while (mag >= MAG_HI) begin
      x = x >>> 1;
      y = y >>> 1;
      mag = (mag_of(x) > mag_of(y)) ? mag_of(x) : mag_of(y);
    end
    while (mag < MAG_LO) begin
      x *= 2; y *= 2; mag *= 2;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_LUT[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_LUT[i];
      end
    end
    return base + z;
  endfunction

  // command for one odometry beat
  function automatic command_t steer_command(input longint px, input longint py,
                                             input longint spd, input longint head,
                                             input logic [63:0] stamp);
    command_t     r;
    int           near, look;
    logic [127:0] d, best, la_sq;
    longint       v, wb, la, h30, s, c, rx, ry, ang, sa, acc, st;
    bit           hit;
    r = '0;
    r.stamp = stamp;
    if (!path_ready || path_len == 0) begin
      r.outcome = OUT_NOPATH;
      return r;
    end
    near = 0;
    best = '0;
    for (int i = 0; i < path_len; i++) begin
      d = sq_dist(longint'(pt_x[i]) - px, longint'(pt_y[i]) - py);
      if (i == 0 || d < best) begin
        near = i;
        best = d;
      end
    end
    if (near == path_len - 1 || path_len <= SHORT_LIMIT) begin
      r.outcome = OUT_STOP;
      r.accel = regs.brake;
      r.accel_def = 1'b1;
      return r;
    end
    r.outcome = OUT_TRACK;
    v = regs.use_fixed ? longint'(regs.fixed_speed) : longint'(pt_spd[near]);
    wb = longint'({1'b0, regs.wheel_base});
    r.speed = v[15:0];
    acc = ((v - spd) * longint'({1'b0, regs.speed_gain}) + 128) >>> 8;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    r.accel = acc[15:0];
    la = ((longint'({1'b0, regs.la_gain}) * v + 32) >>> 6) + longint'({1'b0, regs.la_min});
    h30 = head * 262144;
    rot_sin_cos(h30, s, c);
    rx = px - ((wb * c + (64'sd1 <<< 30)) >>> 31);
    ry = py - ((wb * s + (64'sd1 <<< 30)) >>> 31);
    // first point from the nearest onward that lies on or outside the lookahead circle
    look = path_len - 1;
    la_sq = (la > 0) ? 128'(la) * 128'(la) : '0;
    for (int i = near; i < path_len; i++) begin
      hit = (la <= 0);
      if (!hit) begin
        d = sq_dist(longint'(pt_x[i]) - rx, longint'(pt_y[i]) - ry);
        hit = (d >= la_sq);
      end
      if (hit) begin
        look = i;
        break;
      end
    end
    ang = vec_angle(longint'(pt_y[look]) - ry, longint'(pt_x[look]) - rx);
    rot_sin_cos(ang - h30, sa, c);
    ang = vec_angle(2 * wb * sa, la * (64'sd1 <<< 30));
    st = (ang + 131072) >>> 18;
    if (st > STEER_MAX) st = STEER_MAX;
    if (st < -STEER_MAX) st = -STEER_MAX;
    r.steer = st[14:0];
    return r;
  endfunction

  task automatic report(input string what, input command_t got, input command_t want);
    if (fail_cnt < 20)
      $display({"[%0t] command mismatch (%s): got o=%0d v=%0d a=%0d d=%0d s=%0d t=%h,",
                " want o=%0d v=%0d a=%0d d=%0d s=%0d t=%h"},
               $time, what, got.outcome, got.speed, got.accel, got.accel_def, got.steer,
               got.stamp, want.outcome, want.speed, want.accel, want.accel_def, want.steer,
               want.stamp);
    fail_cnt <= fail_cnt + 1;
  endtask

  always @(posedge clk) begin
    command_t got, want;
    if (!rst_n) begin
      path_len   = 0;
      fill_idx   = 0;
      path_ready = 0;
      regs = '{use_fixed: 1'b0, fixed_speed: 16'sd0, speed_gain: 16'd256,
               la_gain: 16'd256, la_min: 16'd4096, wheel_base: 14'd2867,
               brake: -16'sd256};
      cmd_q.delete();
      fail_cnt <= 0;
      pending  <= 0;
      n_track  <= 0;
      n_nopath <= 0;
      n_stop   <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_USE_FIXED:   regs.use_fixed   = cfg_data[0];
          REG_FIXED_SPEED: regs.fixed_speed = cfg_data;
          REG_SPEED_GAIN:  regs.speed_gain  = cfg_data;
          REG_LA_GAIN:     regs.la_gain     = cfg_data;
          REG_LA_MIN:      regs.la_min      = cfg_data;
          REG_WHEEL_BASE:  regs.wheel_base  = cfg_data[13:0];
          REG_BRAKE:       regs.brake       = cfg_data;
          default: ;
        endcase
      end
      // input beat: path point or query
      if (in_mon.valid && in_mon.ready) begin
        if (!in_mon.mode) begin
          if (fill_idx == 0) begin
            path_ready = 0;
            path_len   = 0;
          end
          if (fill_idx < STORE_DEPTH) begin
            pt_x[fill_idx]   = in_mon.pos_x;
            pt_y[fill_idx]   = in_mon.pos_y;
            pt_spd[fill_idx] = in_mon.speed;
            fill_idx++;
          end
          if (in_mon.last_point) begin
            path_len   = fill_idx;
            path_ready = 1;
            fill_idx   = 0;
          end
        end else begin
          cmd_q.push_back(steer_command(longint'(in_mon.pos_x), longint'(in_mon.pos_y),
                                        longint'(in_mon.speed), longint'(in_mon.heading),
                                        in_mon.stamp));
        end
      end
      // command beat
      if (out_mon.valid && out_mon.ready) begin
        got = '{outcome: out_mon.outcome, speed: out_mon.cmd_speed,
                accel: out_mon.cmd_accel, accel_def: out_mon.accel_defined,
                steer: out_mon.steer_angle, stamp: out_mon.cmd_stamp};
        if (cmd_q.size() == 0) begin
          report("unexpected beat", got, '0);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) report("field", got, want);
          case (want.outcome)
            OUT_TRACK:  n_track  <= n_track + 1;
            OUT_NOPATH: n_nopath <= n_nopath + 1;
            default:    n_stop   <= n_stop + 1;
          endcase
        end
      end
      pending <= cmd_q.size();
    end
  end

endmodule

/* tb/pure_pursuit_steering_controller_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pure_pursuit_steering_controller_tb - top of the controller testbench
// Loads paths and fires odometry queries under random gaps and back-pressure,
// sweeps the registers between phases and leaves checking to the checker.
// ---------------------------------------------------------------------------
module pure_pursuit_steering_controller_tb;
  import pps_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int TARGET_BEATS = 580;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  int  fail_cnt, pending, n_track, n_nopath, n_stop;
  int  n_beats;
  int  n_settings;
  int  idle_cnt;
  bit  calm;
  bit  hold_req, hold_done;
  int  path_px [256];
  int  path_py [256];
  int  path_n;

  pure_pursuit_steering_controller dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  pps_cmd_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_cnt(fail_cnt), .pending(pending), .n_track(n_track),
    .n_nopath(n_nopath), .n_stop(n_stop)
  );

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // command receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    hold_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_beat(input bit mode, input int x, input int y, input int spd,
                           input int hd, input bit last, input logic [63:0] stamp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.mode       <= mode;
    in_ch.pos_x      <= x;
    in_ch.pos_y      <= y;
    in_ch.speed      <= spd[15:0];
    in_ch.heading    <= hd[14:0];
    in_ch.last_point <= last;
    in_ch.stamp      <= stamp;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    n_beats++;
  endtask

  function automatic logic [63:0] rnd_stamp();
    return {$urandom, $urandom};
  endfunction

  function automatic int rnd_heading();
    if ($urandom_range(0, 7) == 0) return $urandom;  // full field, wrapped inside
    return int'($urandom_range(0, 25736)) - 12868;
  endfunction

  function automatic int rnd_speed();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return int'($urandom_range(0, 4000)) - 500;
  endfunction

  // straight-ish path with random content; may slip in a query while loading
  task automatic load_path(input int n);
    int x, y, sx, sy;
    x  = int'($urandom_range(0, 2097152)) - 1048576;
    y  = int'($urandom_range(0, 2097152)) - 1048576;
    sx = int'($urandom_range(0, 6000)) - 3000;
    sy = int'($urandom_range(0, 6000)) - 3000;
    if (sx == 0 && sy == 0) sx = 1000;
    path_n = (n > 256) ? 256 : n;
    for (int i = 0; i < n; i++) begin
      if (i < 256) begin
        path_px[i] = x;
        path_py[i] = y;
      end
      send_beat(1'b0, x, y, rnd_speed(), rnd_heading(), i == n - 1, rnd_stamp());
      if ($urandom_range(0, 40) == 0)
        send_beat(1'b1, x, y, rnd_speed(), rnd_heading(), 1'b0, rnd_stamp());
      x += sx + int'($urandom_range(0, 400)) - 200;
      y += sy + int'($urandom_range(0, 400)) - 200;
    end
  endtask

  // query near a chosen path point, or anywhere at all
  task automatic ask(input bit wild);
    int k;
    if (wild || path_n == 0) begin
      send_beat(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
                rnd_stamp());
    end else begin
      k = (path_n > 2 && $urandom_range(0, 5) != 0) ? $urandom_range(0, path_n - 2)
                                                   : $urandom_range(0, path_n - 1);
      send_beat(1'b1, path_px[k] + int'($urandom_range(0, 800)) - 400,
                path_py[k] + int'($urandom_range(0, 800)) - 400, rnd_speed(),
                rnd_heading(), 1'b0, rnd_stamp());
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // wait until every command is out and the block is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(input int kind);
    case (kind)
      0: begin  // low extremes, zero lookahead
        write_reg(REG_USE_FIXED, 16'd1);
        write_reg(REG_FIXED_SPEED, 16'h8000);
        write_reg(REG_SPEED_GAIN, 16'd0);
        write_reg(REG_LA_GAIN, 16'd0);
        write_reg(REG_LA_MIN, 16'd0);
        write_reg(REG_WHEEL_BASE, 16'd0);
        write_reg(REG_BRAKE, 16'h8000);
      end
      1: begin  // high extremes
        write_reg(REG_USE_FIXED, 16'd1);
        write_reg(REG_FIXED_SPEED, 16'h7FFF);
        write_reg(REG_SPEED_GAIN, 16'hFFFF);
        write_reg(REG_LA_GAIN, 16'hFFFF);
        write_reg(REG_LA_MIN, 16'hFFFF);
        write_reg(REG_WHEEL_BASE, 16'h3FFF);
        write_reg(REG_BRAKE, 16'd0);
      end
      default: begin
        write_reg(REG_USE_FIXED, 16'($urandom_range(0, 1)));
        write_reg(REG_FIXED_SPEED, 16'($urandom));
        write_reg(REG_SPEED_GAIN, 16'($urandom_range(0, 1024)));
        write_reg(REG_LA_GAIN, 16'($urandom_range(0, 1024)));
        write_reg(REG_LA_MIN, 16'($urandom_range(0, 20000)));
        write_reg(REG_WHEEL_BASE, 16'($urandom_range(1000, 5000)));
        write_reg(REG_BRAKE, 16'(-int'($urandom_range(0, 2000))));
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  initial begin
    int phase, nq;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= 1'b0;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.speed      <= '0;
    in_ch.heading    <= '0;
    in_ch.last_point <= 1'b0;
    in_ch.stamp      <= '0;
    calm = 0;
    hold_req = 0;
    n_beats = 0;
    n_settings = 1;
    path_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no path, short path, queries while loading, goal, wrap
    send_beat(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, -12868, 1'b0, '1);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 12868, 1'b0, '0);
    send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 0, 1'b0, '0);
    send_beat(1'b0, 0, 0, 0, 0, 1'b1, '0);
    send_beat(1'b1, 100, -100, 256, 0, 1'b0, 64'h0123_4567_89AB_CDEF);
    send_beat(1'b0, 0, 0, 512, 0, 1'b0, '0);
    send_beat(1'b1, 0, 0, 0, 0, 1'b0, 64'd1);
    for (int i = 1; i < 8; i++) begin
      path_px[i] = i * 3000;
      path_py[i] = i * 500;
      send_beat(1'b0, path_px[i], path_py[i], 512 + i * 64, 0, i == 7, '0);
    end
    path_px[0] = 0;
    path_py[0] = 0;
    path_n = 8;
    send_beat(1'b1, 50, 20, 300, 12868, 1'b0, 64'd2);
    send_beat(1'b1, 21000, 3500, 300, 0, 1'b0, 64'd3);
    send_beat(1'b1, 6000, 1000, 32767, 16'h4000, 1'b0, 64'd4);
    send_beat(1'b1, 9000, 1500, -32768, 16'h3FFF, 1'b0, 64'd0);
    send_beat(1'b1, 3000, 500, 0, -12868, 1'b0, '1);
    settle();

    // random phases, register sweep between them
    phase = 0;
    while (n_beats < TARGET_BEATS) begin
      set_regs(phase);
      calm = (phase % 4 == 3);
      case (phase)
        2:       load_path(258);                     // overfilled store
        4:       load_path($urandom_range(1, 5));    // short path
        default: load_path($urandom_range(6, 30));
      endcase
      nq = (phase == 2) ? 3 : $urandom_range(8, 16);
      if (phase == 5) hold_req = 1;
      for (int q = 0; q < nq; q++) ask($urandom_range(0, 9) == 0);
      settle();
      phase++;
    end

    repeat (200) @(posedge clk);
    $display("Run: %0d input beats over %0d register settings, extremes included.",
             n_beats, n_settings);
    $display("Commands checked: %0d tracking, %0d no path, %0d stop.",
             n_track, n_nopath, n_stop);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d commands missing", fail_cnt, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
